/* rtl/core/fwuks_pkg.sv */
// ----------------------------------------------------------------------------
// fwuks_pkg: shared types and constants for the keyed FIFO
// Field widths, operation codes, status codes and control structs.
// ----------------------------------------------------------------------------
package fwuks_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 16;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 32;
    localparam int PAY_W  = 16;
    localparam int ST_W   = 3;
    localparam int FILL_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_MISS  = 3'd4
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // request accepted: latch it and compare its key
        logic exec;     // run the latched request and load the result
    } cmd_t;

endpackage

/* rtl/core/fwuks_req_if.sv */
// ----------------------------------------------------------------------------
// fwuks_req_if: request channel
// Valid/ready channel carrying one operation, key and payload.
// ----------------------------------------------------------------------------
interface fwuks_req_if;
    logic                              valid;
    logic                              ready;
    logic [fwuks_pkg::OP_W-1:0]        op;
    logic signed [fwuks_pkg::KEY_W-1:0] key;
    logic [fwuks_pkg::PAY_W-1:0]       payload;

    modport source (output valid, output op, output key, output payload, input ready);
    modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

/* rtl/core/fwuks_rsp_if.sv */
// ----------------------------------------------------------------------------
// fwuks_rsp_if: result channel
// Valid/ready channel carrying status, returned entry and fill level.
// ----------------------------------------------------------------------------
interface fwuks_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [fwuks_pkg::ST_W-1:0]         status;
    logic signed [fwuks_pkg::KEY_W-1:0] out_key;
    logic [fwuks_pkg::PAY_W-1:0]        out_payload;
    logic [fwuks_pkg::FILL_W-1:0]       fill_count;
    logic                               is_empty;

    modport source (output valid, output status, output out_key, output out_payload,
                    output fill_count, output is_empty, input ready);
    modport sink   (input valid, input status, input out_key, input out_payload,
                    input fill_count, input is_empty, output ready);
endinterface

/* rtl/core/fwuks_ctrl.sv */
// ----------------------------------------------------------------------------
// fwuks_ctrl: sequencing for the keyed FIFO
// Two-state controller: accept a request, then execute it once the output
// register is free. Holds the result valid flag.
// ----------------------------------------------------------------------------
module fwuks_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output fwuks_pkg::cmd_t   cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign req_ready   = (state_reg == S_IDLE);
    assign cmd.capture = req_valid && (state_reg == S_IDLE);
    assign cmd.exec    = (state_reg == S_EXEC) && out_free;
    assign rsp_valid   = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

/* rtl/core/fwuks_dp.sv */
// ----------------------------------------------------------------------------
// fwuks_dp: entry cells, key match and result register
// Entries live in a row of shifting cells, oldest in cell 0. Every cell
// compares its key with the request key when the request is accepted.
// ----------------------------------------------------------------------------
module fwuks_dp
#(
    parameter int DEPTH        = fwuks_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = fwuks_pkg::PAYLOAD_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  fwuks_pkg::cmd_t                    cmd,
    input  logic [fwuks_pkg::OP_W-1:0]         op,
    input  logic signed [fwuks_pkg::KEY_W-1:0] key,
    input  logic [fwuks_pkg::PAY_W-1:0]        payload,
    output logic [fwuks_pkg::ST_W-1:0]         status,
    output logic signed [fwuks_pkg::KEY_W-1:0] out_key,
    output logic [fwuks_pkg::PAY_W-1:0]        out_payload,
    output logic [fwuks_pkg::FILL_W-1:0]       fill_count,
    output logic                               is_empty
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = PAYLOAD_BITS;
    localparam int KW = fwuks_pkg::KEY_W;
    localparam int FW = fwuks_pkg::FILL_W;
    localparam int YW = fwuks_pkg::PAY_W;

    logic signed [KW-1:0] key_cell_reg [DEPTH];
    logic [PW-1:0]        pay_cell_reg [DEPTH];
    logic [DEPTH-1:0]     match_reg;
    logic [CW-1:0]        count_reg, count_next;

    fwuks_pkg::op_t       op_reg;
    logic signed [KW-1:0] key_reg;
    logic [PW-1:0]        pay_reg;

    fwuks_pkg::status_t   status_reg, status_next;
    logic signed [KW-1:0] rkey_reg, rkey_next;
    logic [PW-1:0]        rpay_reg, rpay_next;
    logic [CW-1:0]        fill_reg;

    logic          hit;
    logic          full;
    logic          empty;
    logic          do_push;
    logic          do_pop;
    logic [PW-1:0] sel_pay;

    assign hit   = |match_reg;
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // keys are unique, so at most one match bit is set
    always_comb
    begin
        sel_pay = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_pay = sel_pay | (match_reg[i] ? pay_cell_reg[i] : '0);
        end
    end

    always_comb
    begin
        status_next = fwuks_pkg::ST_OK;
        rkey_next   = '0;
        rpay_next   = '0;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        case (op_reg)
            fwuks_pkg::OP_INSERT:
            begin
                if (hit)
                begin
                    status_next = fwuks_pkg::ST_DUP;
                end
                else if (full)
                begin
                    status_next = fwuks_pkg::ST_FULL;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            fwuks_pkg::OP_REMOVE, fwuks_pkg::OP_PEEK:
            begin
                if (empty)
                begin
                    status_next = fwuks_pkg::ST_EMPTY;
                end
                else
                begin
                    rkey_next = key_cell_reg[0];
                    rpay_next = pay_cell_reg[0];
                    do_pop    = (op_reg == fwuks_pkg::OP_REMOVE);
                end
            end
            fwuks_pkg::OP_SEARCH:
            begin
                if (hit)
                begin
                    rkey_next = key_reg;
                    rpay_next = sel_pay;
                end
                else
                begin
                    status_next = fwuks_pkg::ST_MISS;
                end
            end
            default:
            begin
                status_next = fwuks_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.exec && do_push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.exec && do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // request latch and per-cell compare
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= fwuks_pkg::op_t'(op);
            key_reg <= key;
            pay_reg <= PW'(payload);
            for (int i = 0; i < DEPTH; i++)
            begin
                match_reg[i] <= (CW'(i) < count_reg) && (key_cell_reg[i] == key);
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            always_ff @(posedge clk)
            begin
                if (cmd.exec && do_pop)
                begin
                    if (g < DEPTH - 1)
                    begin
                        key_cell_reg[g] <= key_cell_reg[(g + 1) % DEPTH];
                        pay_cell_reg[g] <= pay_cell_reg[(g + 1) % DEPTH];
                    end
                end
                else if (cmd.exec && do_push && (count_reg == CW'(g)))
                begin
                    key_cell_reg[g] <= key_reg;
                    pay_cell_reg[g] <= pay_reg;
                end
            end
        end
    endgenerate

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            rkey_reg   <= rkey_next;
            rpay_reg   <= rpay_next;
            fill_reg   <= count_next;
        end
    end

    assign status      = status_reg;
    assign out_key     = rkey_reg;
    assign out_payload = YW'(rpay_reg);
    assign fill_count  = FW'(fill_reg);
    assign is_empty    = (fill_reg == '0);

endmodule

/* rtl/core/fifo_with_unique_key_search_top.sv */
// ----------------------------------------------------------------------------
// fifo_with_unique_key_search_top: bounded FIFO with unique-key search
// Holds up to DEPTH entries (key, payload) in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: op (insert, remove head, peek head, search),
//   key and payload. rsp returns exactly one result per request: status,
//   returned key and payload, fill count and empty flag after the request.
//   The accept cycle compares the key against every cell in parallel; the
//   execute state then runs the request and loads the output register once
//   that register is free. No new request is accepted until the previous
//   one has executed; the result is valid once the output register loads.
//   Remove shifts all cells one place toward the head as it executes.
//   A new request is accepted while the previous result still waits in the
//   output register. If rsp stalls, the block finishes the compare of the
//   next request and holds in execute until the output register frees up,
//   with req.ready low.
//   Reset empties the queue (fill count zero) and drops any pending result;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_with_unique_key_search_top
#(
    parameter int DEPTH        = fwuks_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = fwuks_pkg::PAYLOAD_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    fwuks_req_if.sink    req,
    fwuks_rsp_if.source  rsp
);

    fwuks_pkg::cmd_t cmd;

    fwuks_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .cmd       (cmd)
    );

    fwuks_dp
    #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (req.op),
        .key         (req.key),
        .payload     (req.payload),
        .status      (rsp.status),
        .out_key     (rsp.out_key),
        .out_payload (rsp.out_payload),
        .fill_count  (rsp.fill_count),
        .is_empty    (rsp.is_empty)
    );

endmodule

/* tb/sv/fwuks_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fwuks_tb_pkg: result tracking for the keyed FIFO testbench
// Holds a behavioral copy of the queue (keys, payloads, entry count).
// Each accepted request updates that copy and queues the result it implies.
// Returned results are checked in order against those expected results.
// ----------------------------------------------------------------------------
package fwuks_tb_pkg;

    typedef struct packed {
        fwuks_pkg::status_t                 status;
        logic [fwuks_pkg::KEY_W-1:0]        entry_key;
        logic [fwuks_pkg::PAY_W-1:0]        entry_payload;
        logic [fwuks_pkg::FILL_W-1:0]       fill;
        logic                               empty;
    } queue_result_t;

    class keyed_fifo_scoreboard;

        logic [fwuks_pkg::KEY_W-1:0]  held_keys [fwuks_pkg::DEPTH_DEF];
        logic [fwuks_pkg::PAY_W-1:0]  held_payloads [fwuks_pkg::DEPTH_DEF];
        int unsigned                  held_total;
        queue_result_t                expected_results [$];
        int unsigned                  failures;

        function new();
            held_total = 0;
            failures   = 0;
        endfunction

        // oldest slot holding the key, -1 if none
        function int find_slot(logic [fwuks_pkg::KEY_W-1:0] key);
            for (int i = 0; i < held_total; i++)
            begin
                if (held_keys[i] == key)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        function queue_result_t apply_request(fwuks_pkg::op_t op,
                                              logic [fwuks_pkg::KEY_W-1:0] key,
                                              logic [fwuks_pkg::PAY_W-1:0] payload);
            queue_result_t r;
            int            slot;
            r.status        = fwuks_pkg::ST_OK;
            r.entry_key     = '0;
            r.entry_payload = '0;
            slot            = find_slot(key);
            case (op)
                fwuks_pkg::OP_INSERT:
                begin
                    if (slot >= 0)
                    begin
                        r.status = fwuks_pkg::ST_DUP;
                    end
                    else if (held_total >= fwuks_pkg::DEPTH_DEF)
                    begin
                        r.status = fwuks_pkg::ST_FULL;
                    end
                    else
                    begin
                        held_keys[held_total]     = key;
                        held_payloads[held_total] = payload;
                        held_total++;
                    end
                end
                fwuks_pkg::OP_REMOVE:
                begin
                    if (held_total == 0)
                    begin
                        r.status = fwuks_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        r.entry_key     = held_keys[0];
                        r.entry_payload = held_payloads[0];
                        for (int i = 1; i < held_total; i++)
                        begin
                            held_keys[i-1]     = held_keys[i];
                            held_payloads[i-1] = held_payloads[i];
                        end
                        held_total--;
                    end
                end
                fwuks_pkg::OP_PEEK:
                begin
                    if (held_total == 0)
                    begin
                        r.status = fwuks_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        r.entry_key     = held_keys[0];
                        r.entry_payload = held_payloads[0];
                    end
                end
                default:
                begin
                    if (slot < 0)
                    begin
                        r.status = fwuks_pkg::ST_MISS;
                    end
                    else
                    begin
                        r.entry_key     = held_keys[slot];
                        r.entry_payload = held_payloads[slot];
                    end
                end
            endcase
            r.fill  = held_total[fwuks_pkg::FILL_W-1:0];
            r.empty = (held_total == 0);
            return r;
        endfunction

        function void note_request(fwuks_pkg::op_t op, logic [fwuks_pkg::KEY_W-1:0] key,
                                   logic [fwuks_pkg::PAY_W-1:0] payload);
            expected_results.push_back(apply_request(op, key, payload));
        endfunction

        function void check_result(logic [fwuks_pkg::ST_W-1:0] status,
                                   logic [fwuks_pkg::KEY_W-1:0] key,
                                   logic [fwuks_pkg::PAY_W-1:0] payload,
                                   logic [fwuks_pkg::FILL_W-1:0] fill,
                                   logic empty);
            queue_result_t e;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("ERROR: unexpected result status %0d key %h payload %h fill %0d",
                             status, key, payload, fill);
                end
                return;
            end
            e = expected_results.pop_front();
            if (status !== e.status || key !== e.entry_key || payload !== e.entry_payload ||
                fill !== e.fill || empty !== e.empty)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("ERROR: expected status %0d key %h payload %h fill %0d empty %0d",
                             e.status, e.entry_key, e.entry_payload, e.fill, e.empty);
                    $display("       actual   status %0d key %h payload %h fill %0d empty %0d",
                             status, key, payload, fill, empty);
                end
            end
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

    endclass

endpackage

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for fifo_with_unique_key_search_top
// Directed requests hit empty, full and duplicate-key cases and extreme keys,
// then random requests run in fill and drain stretches over a small key pool
// so that duplicates and search hits are frequent. Requester and responder
// idle at random in several phases, including a long responder hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;
    localparam int KEY_POOL_N  = 24;

    bit   clk;
    logic rst_n;

    fwuks_req_if req_ch ();
    fwuks_rsp_if rsp_ch ();

    fwuks_tb_pkg::keyed_fifo_scoreboard board;

    int          req_idle_pct;
    int          rsp_stall_pct;
    int          hold_requests;
    int unsigned cycle_count;
    logic [fwuks_pkg::KEY_W-1:0] key_pool [KEY_POOL_N];

    fifo_with_unique_key_search_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // responder: random stalls plus an occasional long hold-off
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left     = 0;
        holds_done    = 0;
        rsp_ch.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready = 1'b0;
            end
            else
            begin
                rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            board.check_result(rsp_ch.status, rsp_ch.out_key, rsp_ch.out_payload,
                               rsp_ch.fill_count, rsp_ch.is_empty);
        end
    end

    task automatic send_request(fwuks_pkg::op_t op, logic [fwuks_pkg::KEY_W-1:0] key,
                                logic [fwuks_pkg::PAY_W-1:0] payload);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.op      = op;
        req_ch.key     = key;
        req_ch.payload = payload;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        board.note_request(op, key, payload);
        @(negedge clk);
    endtask

    // alternating fill and drain stretches keep the queue moving between empty and full
    task automatic run_random_phase(int n_items, bit with_hold);
        int                          roll;
        bit                          filling;
        fwuks_pkg::op_t              op;
        logic [fwuks_pkg::KEY_W-1:0] key;
        for (int n = 0; n < n_items; n++)
        begin
            if (with_hold && n == 20)
            begin
                hold_requests++;
            end
            filling = ((n / 30) % 2) == 0;
            roll    = $urandom_range(99);
            if (filling)
            begin
                op = (roll < 55) ? fwuks_pkg::OP_INSERT : (roll < 65) ? fwuks_pkg::OP_REMOVE :
                     (roll < 75) ? fwuks_pkg::OP_PEEK : fwuks_pkg::OP_SEARCH;
            end
            else
            begin
                op = (roll < 15) ? fwuks_pkg::OP_INSERT : (roll < 65) ? fwuks_pkg::OP_REMOVE :
                     (roll < 75) ? fwuks_pkg::OP_PEEK : fwuks_pkg::OP_SEARCH;
            end
            if ($urandom_range(99) < 80)
            begin
                key = key_pool[$urandom_range(KEY_POOL_N-1)];
            end
            else
            begin
                key = $urandom;
            end
            send_request(op, key, 16'($urandom_range(16'hFFFF)));
        end
    endtask

    initial
    begin
        logic [fwuks_pkg::KEY_W-1:0] dir_keys [fwuks_pkg::DEPTH_DEF];
        board          = new();
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.op      = fwuks_pkg::OP_INSERT;
        req_ch.key     = '0;
        req_ch.payload = '0;
        req_idle_pct   = 0;
        rsp_stall_pct  = 0;
        hold_requests  = 0;

        dir_keys[0] = 32'h8000_0000;
        dir_keys[1] = 32'h7FFF_FFFF;
        dir_keys[2] = 32'h0000_0000;
        dir_keys[3] = 32'hFFFF_FFFF;
        dir_keys[4] = 32'h5555_5555;
        dir_keys[5] = 32'hAAAA_AAAA;
        for (int i = 6; i < fwuks_pkg::DEPTH_DEF; i++)
        begin
            dir_keys[i] = 32'h0101_0101 * i + 32'h10;
        end
        for (int i = 0; i < KEY_POOL_N; i++)
        begin
            key_pool[i] = (i < 4) ? dir_keys[i] : $urandom;
        end

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty queue
        send_request(fwuks_pkg::OP_SEARCH, 32'h0, 16'h0);
        send_request(fwuks_pkg::OP_REMOVE, 32'h0, 16'hFFFF);
        send_request(fwuks_pkg::OP_PEEK, 32'hFFFF_FFFF, 16'h0);
        // fill to capacity with extreme keys and payloads
        for (int i = 0; i < fwuks_pkg::DEPTH_DEF; i++)
        begin
            send_request(fwuks_pkg::OP_INSERT, dir_keys[i],
                         (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
                         (i % 2) ? 16'h5555 : 16'hAAAA);
        end
        send_request(fwuks_pkg::OP_INSERT, 32'h1234_5678, 16'h1234);  // full
        send_request(fwuks_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'h4321);  // duplicate wins over full
        send_request(fwuks_pkg::OP_SEARCH, 32'h5555_5555, 16'h0);
        send_request(fwuks_pkg::OP_PEEK, 32'h0, 16'h0);
        send_request(fwuks_pkg::OP_REMOVE, 32'h0, 16'h0);
        send_request(fwuks_pkg::OP_INSERT, 32'h0, 16'hBEEF);          // duplicate, not full

        run_random_phase(212, 1'b1);
        req_idle_pct = 53;
        run_random_phase(212, 1'b0);
        req_idle_pct  = 0;
        rsp_stall_pct = 53;
        run_random_phase(212, 1'b0);
        req_idle_pct  = 15;
        rsp_stall_pct = 15;
        run_random_phase(212, 1'b0);

        req_ch.valid = 1'b0;
        while (board.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (board.failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
